@@ rtl/core/edf_pkg.sv @@
// escaped frame deframer package: frame phase codes, framing bytes and stage structs
// used by every module of the deframer; depends on nothing
`default_nettype none

package edf_pkg;

  localparam logic [7:0] FLAG_BYTE   = 8'hFF;
  localparam logic [7:0] ESCAPE_BYTE = 8'hFE;
  localparam int unsigned LEN_W      = 10;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_BODY = 3'b010,
    PH_ESC  = 3'b100
  } phase_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             is_data;
    logic [LEN_W-1:0] frame_length;
    logic             checksum_ok;
    logic             frame_error;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/edf_in_stage.sv @@
// input register of the deframer: holds one received byte until the decoder takes it
// depends on edf_pkg
`default_nettype none

module edf_in_stage
  import edf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       rx_valid,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            rx_stall,
  output rx_item_t        item
);

  logic       vld;
  logic [7:0] held;
  logic       accept;

  assign rx_stall = vld && !advance;
  assign accept   = rx_valid && !rx_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= accept || (vld && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= rx_byte;
    end
  end

  assign item.vld     = vld;
  assign item.rx_byte = held;

endmodule

`default_nettype wire

@@ rtl/core/edf_decode.sv @@
// frame decoder: hunt, unescape, running xor, one-byte holdback and end marker
// depends on edf_pkg
`default_nettype none

module edf_decode
  import edf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     check_enable,
  input  wire rx_item_t item,
  input  wire logic     advance,
  output logic          emit,
  output result_t       result
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 1);
  localparam int unsigned LW = (CW > LEN_W) ? CW : LEN_W;

  phase_t        phase, phase_next;
  logic          hdr_seen, hdr_seen_next;
  logic [7:0]    held_byte, held_byte_next;
  logic          held_valid, held_valid_next;
  logic [7:0]    running_xor, running_xor_next;
  logic [CW-1:0] decoded_count, decoded_count_next;
  logic          overflow_seen, overflow_seen_next;

  logic [7:0]    b;
  logic [7:0]    d;
  logic          take;
  logic          finish;
  logic          body_path;
  logic          full;
  logic [CW-1:0] len_full;
  logic [LW-1:0] len_wide;
  logic [LEN_W-1:0] len;
  logic          err;

  assign b        = item.rx_byte;
  assign full     = decoded_count >= CW'(MAX_FRAME);
  assign len_full = (decoded_count == '0) ? '0 : decoded_count - CW'(1);
  assign len_wide = LW'(len_full);
  assign len      = (len_wide > LW'(LEN_MAX)) ? LEN_MAX : len_wide[LEN_W-1:0];
  assign err      = (decoded_count < CW'(2)) || overflow_seen ||
                    (check_enable && (running_xor != 8'h00));

  always_comb begin
    phase_next         = phase;
    hdr_seen_next      = hdr_seen;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    running_xor_next   = running_xor;
    decoded_count_next = decoded_count;
    overflow_seen_next = overflow_seen;
    d                  = b;
    take               = 1'b0;
    finish             = 1'b0;
    body_path          = 1'b0;

    case (phase)
      PH_ESC: begin
        d          = ESCAPE_BYTE | b;
        take       = 1'b1;
        phase_next = PH_BODY;
      end
      PH_BODY: begin
        body_path = 1'b1;
      end
      PH_HUNT: begin
        if (b == FLAG_BYTE) begin
          if (!hdr_seen) begin
            hdr_seen_next = 1'b1;
          end else begin
            phase_next = PH_BODY;
          end
        end else begin
          body_path = 1'b1;
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase

    if (body_path) begin
      if (b == FLAG_BYTE) begin
        finish = 1'b1;
      end else if (b == ESCAPE_BYTE) begin
        phase_next = PH_ESC;
      end else begin
        take       = 1'b1;
        phase_next = PH_BODY;
      end
    end

    if (take) begin
      running_xor_next = running_xor ^ d;
      if (full) begin
        overflow_seen_next = 1'b1;
      end else begin
        decoded_count_next = decoded_count + CW'(1);
        held_byte_next     = d;
        held_valid_next    = 1'b1;
      end
    end

    if (finish) begin
      phase_next         = PH_HUNT;
      hdr_seen_next      = 1'b0;
      held_byte_next     = 8'h00;
      held_valid_next    = 1'b0;
      running_xor_next   = 8'h00;
      decoded_count_next = '0;
      overflow_seen_next = 1'b0;
    end
  end

  assign emit = item.vld && (finish || (take && !full && held_valid));

  always_comb begin
    if (finish) begin
      result.data_byte    = 8'h00;
      result.is_data      = 1'b0;
      result.frame_length = len;
      result.checksum_ok  = (running_xor == 8'h00);
      result.frame_error  = err;
    end else begin
      result.data_byte    = held_byte;
      result.is_data      = 1'b1;
      result.frame_length = '0;
      result.checksum_ok  = 1'b0;
      result.frame_error  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      hdr_seen      <= 1'b0;
      held_byte     <= 8'h00;
      held_valid    <= 1'b0;
      running_xor   <= 8'h00;
      decoded_count <= '0;
      overflow_seen <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      hdr_seen      <= hdr_seen_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      running_xor   <= running_xor_next;
      decoded_count <= decoded_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/edf_out_stage.sv @@
// result register of the deframer: holds one data byte or end marker for the consumer
// depends on edf_pkg
`default_nettype none

module edf_out_stage
  import edf_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_res,
  input  wire logic    res_stall,
  output logic         ready,
  output logic         res_valid,
  output result_t      res
);

  assign ready = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ready) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      res <= load_res;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/escaped_frame_deframer.sv @@
// top level of the escaped frame deframer: apb register, input stage, decoder, result stage
// depends on edf_pkg, edf_in_stage, edf_decode, edf_out_stage
`default_nettype none

// Byte-stuffed frame receiver. One raw byte per transfer on the rx channel; up to two
// leading 0xFF bytes open a frame, 0xFE escapes the next byte (decoded as 0xFE OR byte),
// an unescaped 0xFF closes it. Decoded bytes leave one per transfer on the res channel,
// always one byte behind so the trailing checksum is never shown as data; a frame close
// gives a marker (is_data 0) with length, checksum status and error flag. A byte is taken
// every clock cycle while the result channel does not stall; the result a byte causes is
// held in the input register, worked out by the combinational decoder and then
// registered in the result register.
// check_enable (offset 0x0, bit 0, reset 0) makes a nonzero xor a frame error; write it
// only while no frame is in flight.
module escaped_frame_deframer
  import edf_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        rx_valid,
  output logic             rx_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [7:0]       data_byte,
  output logic             is_data,
  output logic [LEN_W-1:0] frame_length,
  output logic             checksum_ok,
  output logic             frame_error
);

  logic     check_enable;
  logic     reg_write;
  rx_item_t item;
  logic     advance;
  logic     out_ready;
  logic     emit;
  result_t  step_res;
  result_t  res;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == 1'b0) ? {31'b0, check_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      check_enable <= 1'b0;
    end else if (reg_write && (paddr[2] == 1'b0)) begin
      check_enable <= pwdata[0];
    end
  end

  assign advance = item.vld && out_ready;

  edf_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx_valid),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .rx_stall (rx_stall),
    .item     (item)
  );

  edf_decode #(
    .MAX_FRAME (MAX_FRAME)
  ) u_decode (
    .clk          (clk),
    .rst          (rst),
    .check_enable (check_enable),
    .item         (item),
    .advance      (advance),
    .emit         (emit),
    .result       (step_res)
  );

  edf_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_res  (step_res),
    .res_stall (res_stall),
    .ready     (out_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  assign data_byte    = res.data_byte;
  assign is_data      = res.is_data;
  assign frame_length = res.frame_length;
  assign checksum_ok  = res.checksum_ok;
  assign frame_error  = res.frame_error;

  a_data_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && is_data |-> (frame_length == '0) && !checksum_ok && !frame_error)
    else $error("data transfer carries marker fields");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_data |-> (32'(frame_length) <= MAX_FRAME - 1))
    else $error("frame length beyond frame bound");

  a_short_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && !is_data && (frame_length == '0) |-> frame_error)
    else $error("short frame without error flag");

endmodule

`default_nettype wire

@@ sim/escaped_frame_deframer_test.sv @@
// testbench for escaped_frame_deframer: drives raw framed bytes, predicts payload bytes
// and frame end markers from its own deframer state, checks every result transfer
// depends on edf_pkg and the escaped_frame_deframer rtl
`default_nettype none

module escaped_frame_deframer_test;
  import edf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_FRAME      = 1024;
  localparam logic [2:0]  CHECK_EN_ADDR  = 3'd0;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_ITEMS   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  data_byte;
  logic        is_data;
  logic [LEN_W-1:0] frame_length;
  logic        checksum_ok;
  logic        frame_error;

  escaped_frame_deframer #(.MAX_FRAME(MAX_FRAME)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .rx_valid(rx_valid), .rx_stall(rx_stall), .rx_byte(rx_byte),
    .res_valid(res_valid), .res_stall(res_stall),
    .data_byte(data_byte), .is_data(is_data), .frame_length(frame_length),
    .checksum_ok(checksum_ok), .frame_error(frame_error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // deframer state mirrored from accepted bytes
  phase_t      fr_phase;
  logic [1:0]  fr_hdr;
  logic [7:0]  fr_held;
  logic        fr_held_vld;
  logic [7:0]  fr_xor;
  int unsigned fr_count;
  logic        fr_ovf;
  logic        check_en;

  result_t     decoded_queue[$];

  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned data_seen;
  int unsigned frames_seen;
  int unsigned bad_frames_seen;
  int unsigned overflow_frames;
  int unsigned idle_cycles;
  int unsigned hold_left;
  int unsigned stall_left;
  bit          send_idle;
  bit          recv_idle;

  function automatic void reset_frame();
    fr_phase    = PH_HUNT;
    fr_hdr      = '0;
    fr_held     = '0;
    fr_held_vld = 1'b0;
    fr_xor      = '0;
    fr_count    = 0;
    fr_ovf      = 1'b0;
  endfunction

  function automatic void take_decoded(logic [7:0] d);
    result_t r;
    fr_xor ^= d;
    if (fr_count >= MAX_FRAME) begin
      fr_ovf = 1'b1;
      return;
    end
    fr_count++;
    if (fr_held_vld) begin
      r = '0;
      r.data_byte = fr_held;
      r.is_data = 1'b1;
      decoded_queue.push_back(r);
    end
    fr_held = d;
    fr_held_vld = 1'b1;
  endfunction

  function automatic void end_frame();
    result_t     r;
    int unsigned len;
    len = (fr_count > 0) ? fr_count - 1 : 0;
    if (len > LEN_MAX) len = LEN_MAX;
    r = '0;
    r.frame_length = len[LEN_W-1:0];
    r.checksum_ok = (fr_xor == 8'h00);
    r.frame_error = (fr_count < 2) || fr_ovf || (check_en && fr_xor != 8'h00);
    if (fr_ovf) overflow_frames++;
    decoded_queue.push_back(r);
    reset_frame();
  endfunction

  function automatic void body_byte(logic [7:0] b);
    if (b == FLAG_BYTE) end_frame();
    else if (b == ESCAPE_BYTE) fr_phase = PH_ESC;
    else take_decoded(b);
  endfunction

  function automatic void decode_rx_byte(logic [7:0] b);
    case (fr_phase)
      PH_ESC: begin
        fr_phase = PH_BODY;
        take_decoded(ESCAPE_BYTE | b);
      end
      PH_BODY: begin
        body_byte(b);
      end
      default: begin
        if (b == FLAG_BYTE) begin
          if (fr_hdr == 2'd0) begin
            fr_hdr = 2'd1;
          end else begin
            fr_hdr = 2'd2;
            fr_phase = PH_BODY;
          end
        end else begin
          fr_phase = PH_BODY;
          body_byte(b);
        end
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit enabled);
    int unsigned r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) return FLAG_BYTE;
    if (r < 25) return ESCAPE_BYTE;
    if (r < 32) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap(send_idle);
    @(negedge clk);
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    decode_rx_byte(b);
    bytes_sent++;
  endtask

  // encodes payload plus xor checksum, or a corrupted one when good_sum is 0, escaping flag and escape values
  task automatic send_frame(input int unsigned n_payload, input int unsigned headers,
                            input bit good_sum);
    logic [7:0] d;
    logic [7:0] sum;
    logic [7:0] low;
    sum = '0;
    repeat (headers) send_byte(FLAG_BYTE);
    for (int unsigned i = 0; i <= n_payload; i++) begin
      if (i < n_payload) begin
        d = pick_payload();
        sum ^= d;
      end else begin
        d = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
      end
      if (d == FLAG_BYTE || d == ESCAPE_BYTE) begin
        low = 8'($urandom_range(0, 255));
        low[0] = d[0];
        send_byte(ESCAPE_BYTE);
        send_byte(low);
      end else begin
        send_byte(d);
      end
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic finish_phase();
    while (!(fr_phase == PH_HUNT && fr_hdr == 2'd0)) send_byte(FLAG_BYTE);
    @(negedge clk);
    rx_valid <= 1'b0;
    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_check_enable(input logic v);
    logic [31:0] rd;
    apb_access(1'b1, CHECK_EN_ADDR, {31'd0, v}, rd);
    check_en = v;
    apb_access(1'b0, CHECK_EN_ADDR, '0, rd);
    if (rd[0] !== v) begin
      $error("check_enable readback: expected %0d, got %0d", v, rd[0]);
      fail_count++;
    end
  endtask

  task automatic test_reset_register();
    logic [31:0] rd;
    apb_access(1'b0, CHECK_EN_ADDR, '0, rd);
    if (rd[0] !== 1'b0) begin
      $error("check_enable after reset: expected 0, got %0d", rd[0]);
      fail_count++;
    end
  endtask

  // empty frame, single-flag open, non-flag opener, escapes including escaped flag
  task automatic test_directed_frames();
    logic [7:0] seq[$];
    seq = '{8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'h5A, 8'hFF,
            8'hC3, 8'hFF,
            8'hFF, 8'hFF, 8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF, 8'hFE, 8'h00,
            8'h01, 8'hFE, 8'hFE, 8'hFF};
    send_idle = 1'b1;
    recv_idle = 1'b1;
    foreach (seq[i]) send_byte(seq[i]);
    finish_phase();
  endtask

  task automatic test_checksum_check(input logic en);
    set_check_enable(en);
    for (int i = 0; i < 6; i++) send_frame($urandom_range(1, 6), 2, i[0]);
    send_frame(1, 2, 1'b1);
    finish_phase();
  endtask

  // one frame running through the size bound and past it, plain bytes only
  task automatic test_long_frames();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    send_byte(FLAG_BYTE);
    send_byte(FLAG_BYTE);
    for (int unsigned i = 0; i < MAX_FRAME + 2; i++) send_byte(8'($urandom_range(0, 253)));
    send_byte(FLAG_BYTE);
    finish_phase();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned r;
    int unsigned hdr;
    stop_at = bytes_sent + n_items;
    while (bytes_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        hdr = $urandom_range(0, 99);
        hdr = (hdr < 75) ? 2 : (hdr < 90) ? 1 : 0;
        send_frame(($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12),
                   hdr, $urandom_range(0, 9) < 7);
      end else if (r < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        // truncated or garbled frame body
        send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        repeat ($urandom_range(1, 8)) send_byte(pick_payload());
      end
    end
    finish_phase();
  endtask

  task automatic test_result_backpressure();
    send_idle = 1'b0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) send_frame($urandom_range(3, 8), 2, 1'b1);
    finish_phase();
  endtask

  // receiver side: random stalls while recv_idle is set, plus one long hold-off from the backpressure test
  always @(negedge clk) begin
    if (hold_left != 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left != 0) begin
      res_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      res_stall <= 1'b0;
      stall_left <= pick_gap(recv_idle);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && res_valid && !res_stall) begin
      if (decoded_queue.size() == 0) begin
        $error("result transfer with nothing pending: data_byte=%0h is_data=%0d",
               data_byte, is_data);
        fail_count++;
      end else begin
        exp_r = decoded_queue.pop_front();
        if (data_byte !== exp_r.data_byte) begin
          $error("data_byte: expected %0h, got %0h", exp_r.data_byte, data_byte);
          fail_count++;
        end
        if (is_data !== exp_r.is_data) begin
          $error("is_data: expected %0d, got %0d", exp_r.is_data, is_data);
          fail_count++;
        end
        if (frame_length !== exp_r.frame_length) begin
          $error("frame_length: expected %0d, got %0d", exp_r.frame_length, frame_length);
          fail_count++;
        end
        if (checksum_ok !== exp_r.checksum_ok) begin
          $error("checksum_ok: expected %0d, got %0d", exp_r.checksum_ok, checksum_ok);
          fail_count++;
        end
        if (frame_error !== exp_r.frame_error) begin
          $error("frame_error: expected %0d, got %0d", exp_r.frame_error, frame_error);
          fail_count++;
        end
        if (exp_r.is_data) begin
          data_seen++;
        end else begin
          frames_seen++;
          if (exp_r.frame_error) bad_frames_seen++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results pending",
               idle_cycles, decoded_queue.size());
      $display("FAIL escaped_frame_deframer");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count = 0;
    bytes_sent = 0;
    data_seen = 0;
    frames_seen = 0;
    bad_frames_seen = 0;
    overflow_frames = 0;
    idle_cycles = 0;
    hold_left = 0;
    stall_left = 0;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    check_en = 1'b0;
    reset_frame();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_register();
    test_directed_frames();
    test_checksum_check(1'b1);
    test_checksum_check(1'b0);
    test_long_frames();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    set_check_enable(1'b1);
    test_random_traffic(RANDOM_ITEMS / 2);
    send_idle = 1'b0;
    recv_idle = 1'b0;
    set_check_enable(1'b0);
    test_random_traffic(RANDOM_ITEMS / 4);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    test_random_traffic(RANDOM_ITEMS / 4);
    test_result_backpressure();

    while (decoded_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d raw bytes, %0d payload bytes, %0d frame markers", bytes_sent,
             data_seen, frames_seen);
    $display("%0d markers flagged an error, %0d frames overflowed, checking on and off",
             bad_frames_seen, overflow_frames);
    if (fail_count == 0) begin
      $display("PASS escaped_frame_deframer");
    end else begin
      $display("FAIL escaped_frame_deframer");
    end
    $finish;
  end

endmodule

`default_nettype wire
